FILE: rtl/sqh_pkg.sv
// Package for the stack/queue/heap trace classifier.
// Holds payload structs, request and verdict codes, and default sizes.
`default_nettype none
package sqh_pkg;
  localparam int unsigned CAPACITY_DEF    = 1024;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  typedef enum logic [1:0] {
    REQ_PUSH  = 2'd0,
    REQ_POP   = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    VERDICT_IMPOSSIBLE = 3'd0,
    VERDICT_STACK      = 3'd1,
    VERDICT_QUEUE      = 3'd2,
    VERDICT_PRIO       = 3'd3,
    VERDICT_NOT_SURE   = 3'd4
  } verdict_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [2:0] verdict;
    logic       overflow;
  } out_item_t;

  // Mismatch flags: bit 0 stack, bit 1 queue, bit 2 heap.
  function automatic logic [2:0] verdict_of(input logic [2:0] flags);
    logic [2:0] r;
    case (flags)
      3'd7:    r = VERDICT_IMPOSSIBLE;
      3'd6:    r = VERDICT_STACK;
      3'd5:    r = VERDICT_QUEUE;
      3'd3:    r = VERDICT_PRIO;
      default: r = VERDICT_NOT_SURE;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

FILE: rtl/stack_queue_heap_trace_classifier.sv
// Top level of the stack/queue/heap trace classifier.
// Depends on sqh_pkg, sqh_front and sqh_back.
//
// Request beats enter through push/full and carry a request code and a
// value. Every request returns one result beat (verdict and overflow) on
// empty/pop, in order. A two-entry request queue parts the front from the
// back, so new requests are taken while a result waits to be popped.
// A clear, a dropped push, an unused code or a pop on empty stores goes
// straight to its result; a pop that empties the stores does the compare
// only; a push compares heap parents one after another on its way up and a
// pop descends the heap level by level on the heap memory's single port.
// One request is worked on at a time; the next starts the cycle after the
// previous result beat is popped.
// Reset empties all stores and flags; memory contents are not cleared.
// When pop stays low, the finished result holds, the back end stops and
// the request queue fills, then full rises.
`default_nettype none
module stack_queue_heap_trace_classifier #(
  parameter int unsigned CAPACITY    = sqh_pkg::CAPACITY_DEF,
  parameter int unsigned VALUE_WIDTH = sqh_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire sqh_pkg::in_item_t  in_data_i,
  output logic                    empty,
  input  wire logic               pop,
  output sqh_pkg::out_item_t      out_data_o
);
  import sqh_pkg::*;

  logic     req_valid, req_take;
  in_item_t req_data;

  sqh_front u_front (
    .clk_i, .rst_ni, .push, .full, .in_data_i,
    .req_valid_o(req_valid), .req_data_o(req_data), .req_take_i(req_take));

  sqh_back #(.CAPACITY(CAPACITY), .VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk_i, .rst_ni, .req_valid_i(req_valid), .req_data_i(req_data),
    .req_take_o(req_take), .empty, .pop, .out_data_o);
endmodule
`default_nettype wire

FILE: rtl/sqh_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module sqh_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  // One access a cycle, read data registered.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule
`default_nettype wire

FILE: rtl/sqh_front.sv
// Front end: accepts request beats and places them in a two-entry queue.
// Depends on sqh_pkg.
`default_nettype none
module sqh_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push,
  output logic                   full,
  input  wire sqh_pkg::in_item_t in_data_i,
  output logic                   req_valid_o,
  output sqh_pkg::in_item_t      req_data_o,
  input  wire logic              req_take_i
);
  import sqh_pkg::*;

  in_item_t   slot_q [2];
  logic       rd_q, wr_q;
  logic [1:0] cnt_q;
  logic       do_wr, do_rd;

  assign full        = (cnt_q == 2'd2);
  assign do_wr       = push && !full;
  assign req_valid_o = (cnt_q != 2'd0);
  assign do_rd       = req_take_i && req_valid_o;
  assign req_data_o  = slot_q[rd_q];

  // Pointer and fill count of the request queue.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_wr) wr_q <= ~wr_q;
      if (do_rd) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slot_q[wr_q] <= in_data_i;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/sqh_back.sv
// Back end: runs each request on the stack, queue and heap memories.
// Depends on sqh_pkg and sqh_ram.
`default_nettype none
module sqh_back #(
  parameter int unsigned CAPACITY    = sqh_pkg::CAPACITY_DEF,
  parameter int unsigned VALUE_WIDTH = sqh_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              req_valid_i,
  input  wire sqh_pkg::in_item_t req_data_i,
  output logic                   req_take_o,
  output logic                   empty,
  input  wire logic              pop,
  output sqh_pkg::out_item_t     out_data_o
);
  import sqh_pkg::*;

  localparam int unsigned AW  = $clog2(CAPACITY);
  localparam int unsigned CW  = $clog2(CAPACITY + 1);
  localparam int unsigned CW1 = CW + 1;
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);
  localparam logic [AW-1:0] LAST = AW'(CAPACITY - 1);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_CMP    = 11'b00000000010,
    S_UP_RD  = 11'b00000000100,
    S_UP_CMP = 11'b00000001000,
    S_LAST   = 11'b00000010000,
    S_DN_L   = 11'b00000100000,
    S_DN_R   = 11'b00001000000,
    S_DN_CMP = 11'b00010000000,
    S_DN_R2  = 11'b00100000000,
    S_WR     = 11'b01000000000,
    S_DONE   = 11'b10000000000
  } state_e;

  state_e state_q;
  logic [VALUE_WIDTH-1:0] val_q, last_q, lch_q;
  logic [CW-1:0] s_cnt_q, h_cnt_q;
  logic [AW-1:0] f_head_q, f_tail_q;
  logic [CW-1:0] pos_q, child_q;
  logic [2:0]   flags_q;
  logic         is_pop_q, ovf_q, out_full_q;
  out_item_t    out_q;

  logic                   s_we, f_we, h_we;
  logic [AW-1:0]          s_addr, f_addr, h_addr;
  logic [VALUE_WIDTH-1:0] s_wd, f_wd, h_wd, s_rd, f_rd, h_rd;
  logic [VALUE_WIDTH-1:0] big_child;

  sqh_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_stack (
    .clk_i, .we_i(s_we), .addr_i(s_addr), .wdata_i(s_wd), .rdata_o(s_rd));
  sqh_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_fifo (
    .clk_i, .we_i(f_we), .addr_i(f_addr), .wdata_i(f_wd), .rdata_o(f_rd));
  sqh_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_heap (
    .clk_i, .we_i(h_we), .addr_i(h_addr), .wdata_i(h_wd), .rdata_o(h_rd));

  logic [CW-1:0] parent;
  logic [CW:0]   lchild;
  assign parent     = (pos_q - CW'(1)) >> 1;
  assign lchild     = {pos_q, 1'b1};
  assign big_child  = (h_rd > lch_q) ? h_rd : lch_q;
  assign req_take_o = (state_q == S_IDLE) && req_valid_i && !out_full_q;
  assign empty      = !out_full_q;
  assign out_data_o = out_q;

  // Memory port control, one access per cycle on each store.
  always_comb begin
    s_we = 1'b0; f_we = 1'b0; h_we = 1'b0;
    s_addr = s_cnt_q[AW-1:0]; f_addr = f_tail_q; h_addr = pos_q[AW-1:0];
    s_wd = val_q; f_wd = val_q; h_wd = val_q;
    unique case (state_q)
      S_IDLE: begin
        s_we   = req_take_o && (req_data_i.req_type == REQ_PUSH) && (s_cnt_q != CAP);
        f_we   = s_we;
        s_wd   = VALUE_WIDTH'(req_data_i.value);
        f_wd   = s_wd;
        s_addr = (req_data_i.req_type == REQ_PUSH) ? s_cnt_q[AW-1:0]
                                                    : AW'(s_cnt_q - CW'(1));
        f_addr = (req_data_i.req_type == REQ_PUSH) ? f_tail_q : f_head_q;
        h_addr = '0;
      end
      S_UP_RD:  h_addr = parent[AW-1:0];
      S_UP_CMP: begin
        // Parent smaller: move it down into pos.
        h_we   = (h_rd < val_q);
        h_addr = pos_q[AW-1:0];
        h_wd   = h_rd;
      end
      S_LAST:   h_addr = h_cnt_q[AW-1:0];
      S_DN_L:   h_addr = lchild[AW-1:0];
      S_DN_R:   h_addr = AW'(child_q + CW'(1));
      S_DN_CMP: begin
        // Only a left child: move it up when it beats the last entry.
        h_we   = (h_rd > last_q);
        h_addr = pos_q[AW-1:0];
        h_wd   = h_rd;
      end
      S_DN_R2:  begin
        // Two children: move the larger one up when it beats the last entry.
        h_we   = (big_child > last_q);
        h_addr = pos_q[AW-1:0];
        h_wd   = big_child;
      end
      S_WR:     begin
        h_we = 1'b1;
        h_wd = is_pop_q ? last_q : val_q;
      end
      default:  ;
    endcase
  end

  // Sequencer for a request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      s_cnt_q <= '0; h_cnt_q <= '0;
      f_head_q <= '0; f_tail_q <= '0;
      flags_q <= '0; out_full_q <= 1'b0;
      is_pop_q <= 1'b0; ovf_q <= 1'b0;
      pos_q <= '0; child_q <= '0;
    end else begin
      // Result register: filled when a request finishes, freed by pop.
      if (state_q == S_DONE) out_full_q <= 1'b1;
      else if (pop && out_full_q) out_full_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (req_take_o) begin
          ovf_q <= 1'b0;
          is_pop_q <= (req_data_i.req_type == REQ_POP);
          case (req_data_i.req_type)
            REQ_PUSH: begin
              if (s_cnt_q == CAP) begin
                ovf_q <= 1'b1;
                state_q <= S_DONE;
              end else begin
                s_cnt_q <= s_cnt_q + CW'(1);
                h_cnt_q <= h_cnt_q + CW'(1);
                f_tail_q <= (f_tail_q == LAST) ? '0 : f_tail_q + AW'(1);
                pos_q <= h_cnt_q;
                state_q <= (h_cnt_q == '0) ? S_WR : S_UP_RD;
              end
            end
            REQ_POP: begin
              if (s_cnt_q == '0) begin
                flags_q <= 3'b111;
                state_q <= S_DONE;
              end else begin
                s_cnt_q <= s_cnt_q - CW'(1);
                h_cnt_q <= h_cnt_q - CW'(1);
                f_head_q <= (f_head_q == LAST) ? '0 : f_head_q + AW'(1);
                state_q <= S_CMP;
              end
            end
            REQ_CLEAR: begin
              s_cnt_q <= '0; h_cnt_q <= '0;
              f_head_q <= '0; f_tail_q <= '0;
              flags_q <= '0;
              state_q <= S_DONE;
            end
            default: state_q <= S_DONE;
          endcase
        end
        S_CMP: begin
          flags_q <= flags_q | {h_rd != val_q, f_rd != val_q, s_rd != val_q};
          pos_q <= '0;
          state_q <= (h_cnt_q == '0) ? S_DONE : S_LAST;
        end
        S_UP_RD: state_q <= S_UP_CMP;
        S_UP_CMP: begin
          if (h_rd < val_q) begin
            pos_q <= parent;
            state_q <= (parent == '0) ? S_WR : S_UP_RD;
          end else begin
            state_q <= S_WR;
          end
        end
        S_LAST: state_q <= S_DN_L;
        S_DN_L: begin
          child_q <= lchild[CW-1:0];
          if (lchild >= {1'b0, h_cnt_q}) state_q <= S_WR;
          else if (lchild + CW1'(1) < {1'b0, h_cnt_q}) state_q <= S_DN_R;
          else state_q <= S_DN_CMP;
        end
        S_DN_R: state_q <= S_DN_R2;
        S_DN_CMP: begin
          // Only left child exists; h_rd is the left child.
          if (h_rd > last_q) begin
            pos_q <= child_q;
            state_q <= S_DN_L;
          end else state_q <= S_WR;
        end
        S_DN_R2: begin
          // lch_q is left child, h_rd right child.
          if (h_rd > lch_q) begin
            if (h_rd > last_q) begin
              pos_q <= child_q + CW'(1);
              state_q <= S_DN_L;
            end else state_q <= S_WR;
          end else if (lch_q > last_q) begin
            pos_q <= child_q;
            state_q <= S_DN_L;
          end else state_q <= S_WR;
        end
        S_WR: state_q <= S_DONE;
        S_DONE: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && req_take_o) val_q <= VALUE_WIDTH'(req_data_i.value);
    if (state_q == S_DN_L) last_q <= (pos_q == '0) ? h_rd : last_q;
    if (state_q == S_DN_R) lch_q <= h_rd;
    if (state_q == S_DONE) begin
      out_q.verdict  <= verdict_of(flags_q);
      out_q.overflow <= ovf_q;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/sqh_checker.sv
// Port-level checks for the trace classifier, bound to the top level.
// Depends on sqh_pkg.
`default_nettype none
module sqh_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               push,
  input wire logic               full,
  input wire logic               empty,
  input wire logic               pop,
  input wire sqh_pkg::out_item_t out_data_o
);
  import sqh_pkg::*;

  // A waiting result beat holds until popped.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_data_o)))
    else $error("result changed while stalled");

  // Verdict is always a defined code.
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_data_o.verdict <= VERDICT_NOT_SURE))
    else $error("undefined verdict");

  // A shown result beat carries no unknown bits.
  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !$isunknown(out_data_o))
    else $error("unknown result beat");

  // The input side only fills up after a request beat was offered.
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push))
    else $error("full rose without a push");
endmodule

bind stack_queue_heap_trace_classifier sqh_checker u_checker (
  .clk_i, .rst_ni, .push, .full, .empty, .pop, .out_data_o);
`default_nettype wire
